// ===== sv/i2cm_pkg.sv =====
// Shared types and constants for the I2C master bit engine.
// Depends on nothing; every other file imports it.
package i2cm_pkg;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  localparam logic [2:0] OP_TICK  = 3'd0;
  localparam logic [2:0] OP_START = 3'd1;
  localparam logic [2:0] OP_STOP  = 3'd2;
  localparam logic [2:0] OP_WRITE = 3'd3;
  localparam logic [2:0] OP_RDACK = 3'd4;
  localparam logic [2:0] OP_RDNAK = 3'd5;

  localparam logic [0:0] REG_HALF_PERIOD = 1'd0;
  localparam logic [0:0] REG_ACK_TIMEOUT = 1'd1;

  localparam logic [15:0] HALF_PERIOD_RST = 16'd2;
  localparam logic [7:0]  ACK_TIMEOUT_RST = 8'd250;
  localparam logic [3:0]  BITS_PER_BYTE   = 4'd8;

  typedef enum logic [2:0] {
    CMD_NONE  = 3'b000,
    CMD_START = 3'b001,
    CMD_STOP  = 3'b010,
    CMD_WRITE = 3'b011,
    CMD_READ  = 3'b100
  } cmd_t;

  typedef struct packed {
    cmd_t       cmd;
    logic       nack;
    logic [7:0] tx_byte;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic scl;
    logic sda;
    logic drv;
  } pins_t;

  typedef struct packed {
    pins_t      pins;
    logic       busy;
    logic       done;
    logic [7:0] rx_byte;
    logic       ack_error;
  } res_t;

  typedef enum logic [13:0] {
    PH_IDLE = 14'b00000000000001,
    PH_ST1  = 14'b00000000000010,
    PH_ST2  = 14'b00000000000100,
    PH_SP1  = 14'b00000000001000,
    PH_SP2  = 14'b00000000010000,
    PH_SP3  = 14'b00000000100000,
    PH_WL   = 14'b00000001000000,
    PH_WH   = 14'b00000010000000,
    PH_AL   = 14'b00000100000000,
    PH_AH   = 14'b00001000000000,
    PH_RL   = 14'b00010000000000,
    PH_RH   = 14'b00100000000000,
    PH_KL   = 14'b01000000000000,
    PH_KH   = 14'b10000000000000
  } phase_t;

endpackage

// ===== sv/i2cm_front.sv =====
// Front end: decode the operation code and hold ticks in a short queue.
// Depends on i2cm_pkg.
module i2cm_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  output logic            full,
  input  logic [2:0]      operation,
  input  logic [7:0]      tx_byte,
  input  logic            sda_in,
  output logic            head_valid,
  output i2cm_pkg::item_t head,
  input  logic            take
);
  import i2cm_pkg::*;

  item_t              mem [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;
  item_t              item_in;
  logic               do_push;
  logic               do_take;

  always_comb begin
    item_in.tx_byte = tx_byte;
    item_in.sda_in  = sda_in;
    item_in.nack    = 1'b0;
    case (operation)
      OP_START: item_in.cmd = CMD_START;
      OP_STOP:  item_in.cmd = CMD_STOP;
      OP_WRITE: item_in.cmd = CMD_WRITE;
      OP_RDACK: item_in.cmd = CMD_READ;
      OP_RDNAK: begin
        item_in.cmd  = CMD_READ;
        item_in.nack = 1'b1;
      end
      default:  item_in.cmd = CMD_NONE;
    endcase
  end

  assign full       = (count == QCNT_W'(QDEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];
  assign do_push    = push && !full;
  assign do_take    = take && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_take) rd_ptr <= rd_ptr + 1'b1;
      count <= count + QCNT_W'(do_push) - QCNT_W'(do_take);
    end
  end

endmodule

// ===== sv/i2cm_engine.sv =====
// Back end: bus phase sequencer and configuration registers, one tick per step.
// Depends on i2cm_pkg.
module i2cm_engine (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [0:0]      cfg_index,
  input  logic [15:0]     cfg_data,
  input  logic            step,
  input  i2cm_pkg::item_t item,
  output i2cm_pkg::res_t  res
);
  import i2cm_pkg::*;

  logic [15:0] half_period_ticks;
  logic [7:0]  ack_timeout_polls;

  phase_t      phase, phase_next;
  logic [15:0] tick_count, tick_count_next;
  logic [3:0]  bit_index, bit_index_next;
  logic [7:0]  shift_byte, shift_byte_next;
  logic [7:0]  poll_count, poll_count_next;
  logic        send_ack_bit, send_ack_bit_next;
  logic        error_flag, error_flag_next;
  logic [7:0]  rx_hold, rx_hold_next;
  pins_t       pins, pins_next;

  logic [15:0] tick_inc;
  logic [3:0]  bit_inc;
  logic        expired;
  logic        do_enter;
  phase_t      enter_ph;
  logic        done;

  // Pin levels shown on the tick that enters a phase.
  function automatic pins_t pin_map(phase_t p, logic msb, pins_t cur, logic ack);
    pins_t r;
    r = cur;
    case (p)
      PH_ST1:  r = '{scl: 1'b1, sda: 1'b1, drv: 1'b1};
      PH_ST2:  r = '{scl: 1'b1, sda: 1'b0, drv: 1'b1};
      PH_SP1:  r = '{scl: 1'b0, sda: 1'b0, drv: 1'b1};
      PH_SP2:  r = '{scl: 1'b1, sda: 1'b0, drv: 1'b1};
      PH_SP3:  r = '{scl: 1'b1, sda: 1'b1, drv: 1'b1};
      PH_WL:   r = '{scl: 1'b0, sda: msb,  drv: 1'b1};
      PH_WH:   r = '{scl: 1'b1, sda: msb,  drv: 1'b1};
      PH_AL:   r = '{scl: 1'b0, sda: cur.sda, drv: 1'b0};
      PH_AH:   r = '{scl: 1'b1, sda: cur.sda, drv: 1'b0};
      PH_RL:   r = '{scl: 1'b0, sda: cur.sda, drv: 1'b0};
      PH_RH:   r = '{scl: 1'b1, sda: cur.sda, drv: 1'b0};
      PH_KL:   r = '{scl: 1'b0, sda: ack,  drv: 1'b1};
      PH_KH:   r = '{scl: 1'b1, sda: ack,  drv: 1'b1};
      default: r = cur;
    endcase
    return r;
  endfunction

  always_comb begin
    phase_next        = phase;
    tick_count_next   = tick_count;
    bit_index_next    = bit_index;
    shift_byte_next   = shift_byte;
    poll_count_next   = poll_count;
    send_ack_bit_next = send_ack_bit;
    error_flag_next   = error_flag;
    rx_hold_next      = rx_hold;
    pins_next         = pins;
    done              = 1'b0;
    do_enter          = 1'b0;
    enter_ph          = PH_IDLE;
    tick_inc          = tick_count + 16'd1;
    bit_inc           = bit_index + 4'd1;
    expired           = (tick_inc >= half_period_ticks);

    if (phase == PH_IDLE) begin
      case (item.cmd)
        CMD_START: begin
          do_enter = 1'b1;
          enter_ph = PH_ST1;
        end
        CMD_STOP: begin
          do_enter = 1'b1;
          enter_ph = PH_SP1;
        end
        CMD_WRITE: begin
          shift_byte_next = item.tx_byte;
          bit_index_next  = '0;
          do_enter        = 1'b1;
          enter_ph        = PH_WL;
        end
        CMD_READ: begin
          shift_byte_next   = '0;
          bit_index_next    = '0;
          send_ack_bit_next = item.nack;
          do_enter          = 1'b1;
          enter_ph          = PH_RL;
        end
        default: ;
      endcase
    end else if (phase == PH_AH) begin
      if (!item.sda_in) begin
        error_flag_next = 1'b0;
        pins_next.scl   = 1'b0;
        pins_next.drv   = 1'b0;
        phase_next      = PH_IDLE;
        tick_count_next = '0;
        done            = 1'b1;
      end else if (poll_count >= ack_timeout_polls) begin
        // no acknowledge in time: flag it and stop the bus
        error_flag_next = 1'b1;
        do_enter        = 1'b1;
        enter_ph        = PH_SP1;
      end else begin
        poll_count_next = poll_count + 8'd1;
      end
    end else begin
      if (phase == PH_RH && tick_count == '0) begin
        shift_byte_next = {shift_byte[6:0], item.sda_in};
      end
      tick_count_next = tick_inc;
      if (expired) begin
        case (phase)
          PH_ST1: begin
            do_enter = 1'b1;
            enter_ph = PH_ST2;
          end
          PH_ST2: begin
            pins_next       = '{scl: 1'b0, sda: 1'b0, drv: 1'b1};
            phase_next      = PH_IDLE;
            tick_count_next = '0;
            done            = 1'b1;
          end
          PH_SP1: begin
            do_enter = 1'b1;
            enter_ph = PH_SP2;
          end
          PH_SP2: begin
            do_enter = 1'b1;
            enter_ph = PH_SP3;
          end
          PH_SP3: begin
            phase_next      = PH_IDLE;
            tick_count_next = '0;
            done            = 1'b1;
          end
          PH_WL: begin
            do_enter = 1'b1;
            enter_ph = PH_WH;
          end
          PH_WH: begin
            bit_index_next  = bit_inc;
            shift_byte_next = {shift_byte[6:0], 1'b0};
            do_enter        = 1'b1;
            enter_ph        = (bit_inc < BITS_PER_BYTE) ? PH_WL : PH_AL;
          end
          PH_AL: begin
            do_enter = 1'b1;
            enter_ph = PH_AH;
          end
          PH_RL: begin
            do_enter = 1'b1;
            enter_ph = PH_RH;
          end
          PH_RH: begin
            bit_index_next = bit_inc;
            do_enter       = 1'b1;
            enter_ph       = (bit_inc < BITS_PER_BYTE) ? PH_RL : PH_KL;
          end
          PH_KL: begin
            do_enter = 1'b1;
            enter_ph = PH_KH;
          end
          PH_KH: begin
            pins_next       = '{scl: 1'b0, sda: send_ack_bit, drv: 1'b1};
            rx_hold_next    = shift_byte_next;
            phase_next      = PH_IDLE;
            tick_count_next = '0;
            done            = 1'b1;
          end
          default: begin
            phase_next      = PH_IDLE;
            tick_count_next = '0;
          end
        endcase
      end
    end

    if (do_enter) begin
      phase_next      = enter_ph;
      tick_count_next = '0;
      pins_next       = pin_map(enter_ph, shift_byte_next[7], pins, send_ack_bit_next);
      if (enter_ph == PH_AH) poll_count_next = '0;
    end

    res.pins      = pins_next;
    res.busy      = (phase_next != PH_IDLE);
    res.done      = done;
    res.rx_byte   = rx_hold_next;
    res.ack_error = error_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period_ticks <= HALF_PERIOD_RST;
      ack_timeout_polls <= ACK_TIMEOUT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HALF_PERIOD: half_period_ticks <= cfg_data;
        REG_ACK_TIMEOUT: ack_timeout_polls <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      tick_count   <= '0;
      bit_index    <= '0;
      shift_byte   <= '0;
      poll_count   <= '0;
      send_ack_bit <= 1'b0;
      error_flag   <= 1'b0;
      rx_hold      <= '0;
      pins         <= '{scl: 1'b1, sda: 1'b1, drv: 1'b1};
    end else if (step) begin
      phase        <= phase_next;
      tick_count   <= tick_count_next;
      bit_index    <= bit_index_next;
      shift_byte   <= shift_byte_next;
      poll_count   <= poll_count_next;
      send_ack_bit <= send_ack_bit_next;
      error_flag   <= error_flag_next;
      rx_hold      <= rx_hold_next;
      pins         <= pins_next;
    end
  end

endmodule

// ===== sv/i2cm_res_q.sv =====
// Result queue: holds finished words until the consumer pops them.
// Depends on i2cm_pkg.
module i2cm_res_q (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  i2cm_pkg::res_t din,
  output logic           full,
  output logic           empty,
  input  logic           pop,
  output i2cm_pkg::res_t dout
);
  import i2cm_pkg::*;

  res_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign full    = (count == QCNT_W'(QDEPTH));
  assign empty   = (count == '0);
  assign dout    = mem[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end
  end

endmodule

// ===== sv/i2c_master_bit_engine.sv =====
// Top level of the I2C master bit engine: front queue, phase sequencer, result queue.
// Depends on i2cm_pkg, i2cm_front, i2cm_engine and i2cm_res_q.
//
// Each pushed word is one bus time tick carrying the sampled SDA level and,
// when the engine is idle, an optional command (start, stop, write byte with
// acknowledge wait, read byte with ACK or NACK). Every tick yields exactly one
// result word showing the pin levels, busy, a done pulse, the last read byte
// and the acknowledge error flag after that tick. The block takes one tick per
// clock unless a full queue holds it off: a two-word front queue feeds the phase
// sequencer, which handles one tick per cycle when stepped, with a single 16-bit
// increment and compare, and a two-word result queue sits in front of the consumer.
// When neither side stalls, a result is on the result ports just after the edge that
// takes its tick and can be popped at the next edge. Write the two timing
// registers (half period at index 0, acknowledge poll limit at index 1) only
// while no tick is in flight.
module i2c_master_bit_engine (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // tick input queue
  input  logic        push,
  output logic        full,
  input  logic [2:0]  operation,
  input  logic [7:0]  tx_byte,
  input  logic        sda_in,
  // result queue
  output logic        empty,
  input  logic        pop,
  output logic        scl_level,
  output logic        sda_level,
  output logic        sda_drive,
  output logic        busy_res,
  output logic        done_res,
  output logic [7:0]  rx_byte,
  output logic        ack_error
);
  import i2cm_pkg::*;

  item_t head;
  logic  head_valid;
  logic  res_full;
  logic  step;
  res_t  eng_res;
  res_t  out_res;

  // Advance the sequencer only when a tick waits and its result has a slot.
  assign step = head_valid && !res_full;

  i2cm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .operation  (operation),
    .tx_byte    (tx_byte),
    .sda_in     (sda_in),
    .head_valid (head_valid),
    .head       (head),
    .take       (step)
  );

  i2cm_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (step),
    .item      (head),
    .res       (eng_res)
  );

  i2cm_res_q u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (step),
    .din   (eng_res),
    .full  (res_full),
    .empty (empty),
    .pop   (pop),
    .dout  (out_res)
  );

  // Drive the result ports from the oldest queued word.
  assign scl_level = out_res.pins.scl;
  assign sda_level = out_res.pins.sda;
  assign sda_drive = out_res.pins.drv;
  assign busy_res  = out_res.busy;
  assign done_res  = out_res.done;
  assign rx_byte   = out_res.rx_byte;
  assign ack_error = out_res.ack_error;

endmodule

// ===== verif/i2c_master_bit_engine_chk.sv =====
// Scoreboard for the I2C master bit engine: watches the tick, result and register ports.
// Keeps its own bus-phase model and compares every popped result word field by field.
// Depends on i2cm_pkg for the operation codes, register indexes, phases and result type.
module i2c_master_bit_engine_chk (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        push,
  input  logic        full,
  input  logic [2:0]  operation,
  input  logic [7:0]  tx_byte,
  input  logic        sda_in,
  input  logic        empty,
  input  logic        pop,
  input  logic        scl_level,
  input  logic        sda_level,
  input  logic        sda_drive,
  input  logic        busy_res,
  input  logic        done_res,
  input  logic [7:0]  rx_byte,
  input  logic        ack_error,
  output int          pending,
  output int          fail_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import i2cm_pkg::*;

  logic [15:0] half_ticks;
  logic [7:0]  poll_limit;
  phase_t      ph;
  logic [15:0] tick_cnt;
  logic [3:0]  bit_cnt;
  logic [7:0]  shreg;
  logic [7:0]  polls_seen;
  logic        ack_bit;
  logic        err;
  logic [7:0]  rx_last;
  pins_t       pins;
  res_t        due_words[$];

  initial begin
    pending    = 0;
    fail_count = 0;
  end

  function automatic void set_pins(logic s, logic d, logic v);
    pins.scl = s;
    pins.sda = d;
    pins.drv = v;
  endfunction

  function automatic void enter_phase(phase_t p);
    ph       = p;
    tick_cnt = '0;
    case (p)
      PH_ST1: set_pins(1'b1, 1'b1, 1'b1);
      PH_ST2: set_pins(1'b1, 1'b0, 1'b1);
      PH_SP1: set_pins(1'b0, 1'b0, 1'b1);
      PH_SP2: set_pins(1'b1, 1'b0, 1'b1);
      PH_SP3: set_pins(1'b1, 1'b1, 1'b1);
      PH_WL:  set_pins(1'b0, shreg[7], 1'b1);
      PH_WH:  set_pins(1'b1, shreg[7], 1'b1);
      PH_AL:  set_pins(1'b0, pins.sda, 1'b0);
      PH_AH: begin
        set_pins(1'b1, pins.sda, 1'b0);
        polls_seen = '0;
      end
      PH_RL:  set_pins(1'b0, pins.sda, 1'b0);
      PH_RH:  set_pins(1'b1, pins.sda, 1'b0);
      PH_KL:  set_pins(1'b0, ack_bit, 1'b1);
      PH_KH:  set_pins(1'b1, ack_bit, 1'b1);
      default: ;
    endcase
  endfunction

  function automatic void go_idle();
    ph       = PH_IDLE;
    tick_cnt = '0;
  endfunction

  // Advance the bus model by one tick and return the word it must produce.
  function automatic res_t bus_tick(logic [2:0] op, logic [7:0] txb, logic s);
    res_t r;
    logic fin;
    fin = 1'b0;
    if (ph == PH_IDLE) begin
      case (op)
        OP_START: enter_phase(PH_ST1);
        OP_STOP:  enter_phase(PH_SP1);
        OP_WRITE: begin
          shreg   = txb;
          bit_cnt = '0;
          enter_phase(PH_WL);
        end
        OP_RDACK, OP_RDNAK: begin
          shreg   = '0;
          bit_cnt = '0;
          ack_bit = (op == OP_RDNAK);
          enter_phase(PH_RL);
        end
        default: ;
      endcase
    end else if (ph == PH_AH) begin
      if (!s) begin
        err = 1'b0;
        set_pins(1'b0, pins.sda, 1'b0);
        go_idle();
        fin = 1'b1;
      end else if (polls_seen >= poll_limit) begin
        err = 1'b1;
        enter_phase(PH_SP1);
      end else begin
        polls_seen = polls_seen + 8'd1;
      end
    end else begin
      if (ph == PH_RH && tick_cnt == '0)
        shreg = {shreg[6:0], s};
      tick_cnt = tick_cnt + 16'd1;
      if (tick_cnt >= half_ticks) begin
        case (ph)
          PH_ST1: enter_phase(PH_ST2);
          PH_ST2: begin
            set_pins(1'b0, 1'b0, 1'b1);
            go_idle();
            fin = 1'b1;
          end
          PH_SP1: enter_phase(PH_SP2);
          PH_SP2: enter_phase(PH_SP3);
          PH_SP3: begin
            go_idle();
            fin = 1'b1;
          end
          PH_WL: enter_phase(PH_WH);
          PH_WH: begin
            bit_cnt = bit_cnt + 4'd1;
            shreg   = shreg << 1;
            if (bit_cnt < BITS_PER_BYTE) enter_phase(PH_WL);
            else enter_phase(PH_AL);
          end
          PH_AL: enter_phase(PH_AH);
          PH_RL: enter_phase(PH_RH);
          PH_RH: begin
            bit_cnt = bit_cnt + 4'd1;
            if (bit_cnt < BITS_PER_BYTE) enter_phase(PH_RL);
            else enter_phase(PH_KL);
          end
          PH_KL: enter_phase(PH_KH);
          PH_KH: begin
            set_pins(1'b0, ack_bit, 1'b1);
            rx_last = shreg;
            go_idle();
            fin = 1'b1;
          end
          default: go_idle();
        endcase
      end
    end
    r.pins      = pins;
    r.busy      = (ph != PH_IDLE);
    r.done      = fin;
    r.rx_byte   = rx_last;
    r.ack_error = err;
    return r;
  endfunction

  function automatic void check_field(string name, logic [7:0] expv, logic [7:0] actv);
    if (expv !== actv) begin
      $error("%s mismatch: expected %0h, actual %0h", name, expv, actv);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      half_ticks = HALF_PERIOD_RST;
      poll_limit = ACK_TIMEOUT_RST;
      ph         = PH_IDLE;
      tick_cnt   = '0;
      bit_cnt    = '0;
      shreg      = '0;
      polls_seen = '0;
      ack_bit    = 1'b0;
      err        = 1'b0;
      rx_last    = '0;
      set_pins(1'b1, 1'b1, 1'b1);
      due_words.delete();
    end else begin
      if (pop && !empty) begin
        if (due_words.size() == 0) begin
          $error("result word popped with no word expected");
          fail_count++;
        end else begin
          want = due_words.pop_front();
          check_field("scl_level", want.pins.scl, scl_level);
          check_field("sda_level", want.pins.sda, sda_level);
          check_field("sda_drive", want.pins.drv, sda_drive);
          check_field("busy_res", want.busy, busy_res);
          check_field("done_res", want.done, done_res);
          check_field("rx_byte", want.rx_byte, rx_byte);
          check_field("ack_error", want.ack_error, ack_error);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_HALF_PERIOD: half_ticks = cfg_data;
          REG_ACK_TIMEOUT: poll_limit = cfg_data[7:0];
          default: ;
        endcase
      end
      if (push && !full)
        due_words.push_back(bus_tick(operation, tx_byte, sda_in));
    end
    pending = due_words.size();
  end

endmodule

// ===== verif/i2c_master_bit_engine_tb.sv =====
// Testbench top for the I2C master bit engine: clock, reset, tick stimulus and verdict.
// Depends on i2cm_pkg, the engine RTL and i2c_master_bit_engine_chk, which does all checking.
module i2c_master_bit_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import i2cm_pkg::*;

  // Codes the block must treat as a plain tick.
  localparam logic [2:0] OP_UNUSED6 = 3'd6;
  localparam logic [2:0] OP_UNUSED7 = 3'd7;

  // How the sampled SDA line behaves while a command runs.
  localparam int SDA_LOW  = 0;
  localparam int SDA_HIGH = 1;
  localparam int SDA_RAND = 2;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int HOLD_CYCLES   = 60;
  localparam int SETTLE_CYCLES = 8;
  localparam int RAND_PHASES   = 8;
  localparam int RAND_WORDS    = 16;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        cfg_we    = 1'b0;
  logic [0:0]  cfg_index = REG_HALF_PERIOD;
  logic [15:0] cfg_data  = '0;
  logic        push      = 1'b0;
  logic [2:0]  operation = OP_TICK;
  logic [7:0]  tx_byte   = '0;
  logic        sda_in    = 1'b1;
  logic        pop       = 1'b0;
  logic        full;
  logic        empty;
  logic        scl_level;
  logic        sda_level;
  logic        sda_drive;
  logic        busy_res;
  logic        done_res;
  logic [7:0]  rx_byte;
  logic        ack_error;
  int          pending;
  int          fail_count;

  // Pacing knobs, read by the sender task and the receiver process.
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int          hold_asks      = 0;
  int          send_pcts[4]   = '{0, 53, 0, 9};
  int          recv_pcts[4]   = '{0, 0, 53, 9};

  // Timing currently programmed, used only to size the tick runs.
  logic [15:0] cur_half  = HALF_PERIOD_RST;
  logic [7:0]  cur_polls = ACK_TIMEOUT_RST;

  i2c_master_bit_engine i_dut (.*);

  i2c_master_bit_engine_chk i_chk (.*);

  always #1 clk = ~clk;

  // Watchdog: end the run if the stimulus or the drain never completes.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("TEST FAILED");
    $finish;
  end

  // Receiver: pop at random, and on request hold off for a long stretch so the
  // result queue backs up into the tick queue and full rises.
  initial begin : pop_side
    int holds_served;
    holds_served = 0;
    forever begin
      @(negedge clk);
      if (holds_served != hold_asks) begin
        holds_served++;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic logic line_level(int mode);
    case (mode)
      SDA_LOW:  return 1'b0;
      SDA_HIGH: return 1'b1;
      default:  return logic'($urandom_range(1));
    endcase
  endfunction

  // Offer one tick word; idle first at random (with junk on the payload), then
  // hold push until the block takes the word. Leave push high for the next call.
  task automatic send_word(input logic [2:0] op, input logic [7:0] b, input logic s);
    while ($urandom_range(99) < send_idle_pct) begin
      push      <= 1'b0;
      operation <= 3'($urandom);
      tx_byte   <= 8'($urandom);
      @(negedge clk);
    end
    push      <= 1'b1;
    operation <= op;
    tx_byte   <= b;
    sda_in    <= s;
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
  endtask

  // Drop push and wait until every expected word is back, then let the block settle.
  task automatic wait_drained();
    push <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Program both timing registers on back-to-back cycles while nothing is in flight.
  task automatic set_timing(input logic [15:0] h, input logic [7:0] p);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= REG_HALF_PERIOD;
    cfg_data  <= h;
    @(negedge clk);
    cfg_index <= REG_ACK_TIMEOUT;
    cfg_data  <= {8'd0, p};
    @(negedge clk);
    cfg_we    <= 1'b0;
    cur_half  = h;
    cur_polls = p;
  endtask

  // Issue one command, then enough plain ticks for the engine to finish it.
  // With poke_busy set, the first ticks after the command carry new commands
  // that the busy engine must ignore.
  task automatic run_cmd(input logic [2:0] op, input logic [7:0] b, input int mode,
                         input bit poke_busy);
    int span;
    int fill;
    int i;
    logic [2:0] fop;
    span = int'(cur_half) + 1;
    case (op)
      OP_START: fill = 2 * span + 2;
      OP_STOP:  fill = 3 * span + 2;
      default:  fill = 23 * span + 2 + ((mode == SDA_HIGH) ? int'(cur_polls) + 2 : 0);
    endcase
    send_word(op, b, line_level(mode));
    for (i = 0; i < fill; i++) begin
      fop = (poke_busy && i < 2) ? 3'($urandom_range(OP_RDNAK, OP_START)) : OP_TICK;
      send_word(fop, 8'($urandom), line_level(mode));
    end
  endtask

  // Random ticks: mostly plain ticks with commands sprinkled in, SDA in runs of
  // low, high or noise so acknowledges, timeouts and read data all vary.
  task automatic random_run(input int count);
    int i;
    int seg_left;
    int seg_mode;
    int pick;
    logic [2:0] op;
    seg_left = 0;
    seg_mode = SDA_RAND;
    for (i = 0; i < count; i++) begin
      if (seg_left == 0) begin
        seg_mode = $urandom_range(SDA_RAND, SDA_LOW);
        seg_left = $urandom_range(16, 1);
      end
      seg_left--;
      pick = $urandom_range(99);
      if (pick < 70) op = OP_TICK;
      else if (pick < 95) op = 3'($urandom_range(OP_RDNAK, OP_START));
      else op = (pick < 98) ? OP_UNUSED6 : OP_UNUSED7;
      send_word(op, 8'($urandom), line_level(seg_mode));
    end
  endtask

  initial begin : stimulus
    int k;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part at the reset timing (half period 2, poll limit 250).
    send_idle_pct  = 9;
    recv_stall_pct = 9;
    send_word(OP_TICK, 8'h00, 1'b0);
    send_word(OP_TICK, 8'hFF, 1'b1);
    send_word(OP_UNUSED6, 8'h5A, 1'b1);
    send_word(OP_UNUSED7, 8'hA5, 1'b0);
    run_cmd(OP_START, 8'h00, SDA_RAND, 1'b0);
    run_cmd(OP_WRITE, 8'hA5, SDA_LOW, 1'b1);
    run_cmd(OP_RDNAK, 8'h00, SDA_RAND, 1'b0);
    run_cmd(OP_STOP, 8'h00, SDA_RAND, 1'b0);

    // Zero poll limit: the first high sample is already the error.
    set_timing(16'd1, 8'd0);
    run_cmd(OP_WRITE, 8'h3C, SDA_HIGH, 1'b0);
    run_cmd(OP_RDACK, 8'h00, SDA_RAND, 1'b0);

    // Zero half period acts as one tick; no acknowledge runs out the poll limit
    // and the engine issues a stop on its own.
    set_timing(16'd0, 8'd20);
    run_cmd(OP_START, 8'h00, SDA_RAND, 1'b0);
    run_cmd(OP_WRITE, 8'h96, SDA_HIGH, 1'b0);
    run_cmd(OP_STOP, 8'h00, SDA_RAND, 1'b0);

    // Longer half period: one start condition at full speed.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    set_timing(16'd21, 8'd1);
    run_cmd(OP_START, 8'h00, SDA_RAND, 1'b0);

    // Random part: walk the pacing modes and a spread of timings. Phase four
    // runs the sender flat out while the receiver holds off.
    for (k = 0; k < RAND_PHASES; k++) begin
      send_idle_pct  = send_pcts[k % 4];
      recv_stall_pct = recv_pcts[k % 4];
      case (k)
        0: set_timing(16'd1, 8'd1);
        1: set_timing(16'd3, 8'd0);
        2: set_timing(16'd2, 8'd5);
        3: set_timing(16'd0, 8'd2);
        4: set_timing(16'($urandom_range(4, 1)), 8'd255);
        5: set_timing(16'd1, 8'($urandom_range(8, 0)));
        6: set_timing(16'($urandom_range(5, 1)), 8'($urandom_range(20, 0)));
        default: set_timing(16'd2, 8'd3);
      endcase
      if (k == 4) hold_asks++;
      random_run(RAND_WORDS);
    end

    // Drain, let the pipeline settle, then give the verdict.
    wait_drained();
    if (fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
